FILE: hw/rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement stack.
`timescale 1ns / 1ps
package lrupr_pkg;

  localparam int unsigned FramesDefault   = 64;
  localparam int unsigned PageBitsDefault = 16;
  localparam int unsigned PageFieldW      = 16;
  localparam int unsigned FramesCfgW      = 7;
  localparam int unsigned FramesCfgReset  = 64;

  // Control part of a reference beat as it walks down the cell row.
  typedef struct packed {
    logic valid;   // a reference occupies this stage
    logic hit;     // page already found in an earlier cell
    logic cvalid;  // valid bit of the entry being shifted down
  } tok_ctrl_t;

endpackage

FILE: hw/rtl/lrupr_cell.sv
// One cell of the recency stack: holds an entry and shifts it along as a reference passes.
`timescale 1ns / 1ps
module lrupr_cell import lrupr_pkg::*; #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned PAGE_BITS = PageBitsDefault,
  parameter int unsigned IW        = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [IW-1:0]        lim_m1_i,
  input  tok_ctrl_t            tok_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [PAGE_BITS-1:0] carry_i,
  output tok_ctrl_t            tok_o,
  output logic [PAGE_BITS-1:0] page_o,
  output logic [PAGE_BITS-1:0] carry_o,
  output logic                 slot_valid_o
);

  localparam logic [IW-1:0] IdxL = IW'(IDX);

  logic [PAGE_BITS-1:0] entry_q, entry_d;
  logic                 valid_q, valid_d;
  tok_ctrl_t            tok_q, tok_d;
  logic [PAGE_BITS-1:0] page_q, carry_q, carry_d;
  logic                 in_range, match;

  assign in_range = (IdxL <= lim_m1_i);
  assign match    = valid_q && (entry_q == page_i);

  always_comb begin
    tok_d   = tok_i;
    carry_d = carry_i;
    entry_d = entry_q;
    valid_d = valid_q;
    if (tok_i.valid && !tok_i.hit) begin
      if (in_range) begin
        // swap: take the entry from above, hand ours further down
        entry_d      = carry_i;
        valid_d      = tok_i.cvalid;
        carry_d      = entry_q;
        tok_d.cvalid = valid_q;
        tok_d.hit    = match;
      end else begin
        // miss past the frame limit: drop whatever lies here
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
      page_q  <= page_i;
      carry_q <= carry_d;
    end
  end

  assign tok_o        = tok_q;
  assign page_o       = page_q;
  assign carry_o      = carry_q;
  assign slot_valid_o = valid_q;

endmodule

FILE: hw/rtl/lru_page_replacement.sv
// Top level of the LRU page replacement stack: cell row, frame limit and output register.
// Usage:
//   s_axis carries page references (tdata = page_number). Each reference
//   produces exactly one beat on m_axis: tdata = the page number, tuser = fault
//   flag (1 when the page was not resident).
//   A reference walks down a row of FRAMES compare-and-shift cells, each
//   registered, then lands in an output register. References enter one per
//   cycle while the receiver does not stall, since each cell finishes with
//   one reference before the next one reaches it.
//   cfg_we_i / cfg_wdata_i set the number of frames in use (0 acts as 1,
//   values above FRAMES saturate); write only while no reference is in flight.
//   Reset empties the stack and sets the frame count to 64 (or FRAMES if
//   smaller). No clearing pass is needed, valid bits are flops.
//   When the receiver stalls with a beat held in the output register, the
//   whole cell row freezes and s_axis_tready drops in the same cycle.
`timescale 1ns / 1ps
module lru_page_replacement import lrupr_pkg::*; #(
  parameter int unsigned FRAMES    = FramesDefault,
  parameter int unsigned PAGE_BITS = PageBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [FramesCfgW-1:0] cfg_wdata_i,   // frames_in_use
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PageFieldW-1:0] s_axis_tdata,  // [15:0] page_number
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PageFieldW-1:0] m_axis_tdata,  // [15:0] page_echo
  output logic                  m_axis_tuser   // [0] page_fault
);

  localparam int unsigned IW        = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned LimReset  = (FramesCfgReset < FRAMES) ? FramesCfgReset : FRAMES;

  logic [IW-1:0]        lim_m1_q, lim_m1_d;
  int unsigned          cfg_n;
  logic                 adv;
  logic                 out_valid_q;
  logic [PAGE_BITS-1:0] out_page_q;
  logic                 out_fault_q;
  logic [31:0]          in_wide, out_wide;
  logic [FRAMES-1:0]    slot_vld;

  tok_ctrl_t            tok   [FRAMES+1];
  logic [PAGE_BITS-1:0] page_c  [FRAMES+1];
  logic [PAGE_BITS-1:0] carry_c [FRAMES+1];

  // frame limit, clamped to 1..FRAMES and kept as limit - 1
  always_comb begin
    cfg_n = 32'(cfg_wdata_i);
    if (cfg_n == 0) cfg_n = 1;
    if (cfg_n > FRAMES) cfg_n = FRAMES;
    lim_m1_d = IW'(cfg_n - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_m1_q <= IW'(LimReset - 1);
    end else if (cfg_we_i) begin
      lim_m1_q <= lim_m1_d;
    end
  end

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  assign in_wide    = 32'(s_axis_tdata);
  assign page_c[0]  = in_wide[PAGE_BITS-1:0];
  assign carry_c[0] = in_wide[PAGE_BITS-1:0];
  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = s_axis_tvalid;
    tok[0].cvalid = 1'b1;
  end

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lrupr_cell #(
      .IDX       (i),
      .PAGE_BITS (PAGE_BITS),
      .IW        (IW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (adv),
      .lim_m1_i     (lim_m1_q),
      .tok_i        (tok[i]),
      .page_i       (page_c[i]),
      .carry_i      (carry_c[i]),
      .tok_o        (tok[i+1]),
      .page_o       (page_c[i+1]),
      .carry_o      (carry_c[i+1]),
      .slot_valid_o (slot_vld[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tok[FRAMES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_page_q  <= page_c[FRAMES];
      out_fault_q <= !tok[FRAMES].hit;
    end
  end

  assign out_wide      = 32'(out_page_q);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_wide[PageFieldW-1:0];
  assign m_axis_tuser  = out_fault_q;

  // a stalled output beat holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output beat changed while stalled");

  // an accepted beat always leaves the front cell occupied
  a_front_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> slot_vld[0])
    else $error("front cell empty after a reference");

  // a frozen row must not lose the beat waiting at its end
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && tok[FRAMES].valid) |=> tok[FRAMES].valid)
    else $error("beat at end of row dropped during stall");

endmodule

FILE: tb/tb_lru_page_replacement.sv
// Self-checking testbench for the LRU page replacement stack.
`timescale 1ns / 1ps
module tb_lru_page_replacement;
  import lrupr_pkg::*;

  localparam int unsigned Frames     = FramesDefault;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [PageFieldW-1:0] page;
    logic                  fault;
  } page_result_t;

  // Mirror of the recency stack; one expected beat per accepted reference.
  class lru_recency_tracker;
    logic [PageFieldW-1:0] stack_q [Frames];
    bit                    occupied [Frames];
    int unsigned           frame_cfg;
    page_result_t          expected_refs [$];
    int unsigned           errors;
    int unsigned           faults;
    int unsigned           hits;

    function new();
      foreach (occupied[i]) begin
        occupied[i] = 1'b0;
        stack_q[i]  = '0;
      end
      frame_cfg = FramesCfgReset;
      errors    = 0;
      faults    = 0;
      hits      = 0;
    endfunction

    function void set_frames(logic [FramesCfgW-1:0] v);
      frame_cfg = 32'(v);
    endfunction

    function int unsigned pending();
      return expected_refs.size();
    endfunction

    function void note_reference(logic [PageFieldW-1:0] pg);
      int unsigned  lim;
      int unsigned  hit_at;
      bit           hit;
      page_result_t r;
      lim = frame_cfg;
      if (lim < 1) lim = 1;
      if (lim > Frames) lim = Frames;
      hit    = 1'b0;
      hit_at = 0;
      for (int unsigned i = 0; i < lim; i++) begin
        if (!hit && occupied[i] && stack_q[i] == pg) begin
          hit    = 1'b1;
          hit_at = i;
        end
      end
      if (hit) begin
        for (int unsigned i = hit_at; i > 0; i--) stack_q[i] = stack_q[i-1];
      end else begin
        // entries at or past the new limit fall off before the push
        for (int unsigned i = lim - 1; i < Frames; i++) occupied[i] = 1'b0;
        for (int unsigned i = lim - 1; i > 0; i--) begin
          stack_q[i]  = stack_q[i-1];
          occupied[i] = occupied[i-1];
        end
        occupied[0] = 1'b1;
      end
      stack_q[0] = pg;
      r.page  = pg;
      r.fault = !hit;
      expected_refs.push_back(r);
    endfunction

    function void check_result(logic [PageFieldW-1:0] pg, logic fault);
      page_result_t e;
      if (expected_refs.size() == 0) begin
        $display("%0t: unexpected beat page=%h fault=%b", $time, pg, fault);
        errors++;
        return;
      end
      e = expected_refs.pop_front();
      if (fault) faults++;
      else hits++;
      if (pg !== e.page) begin
        $display("%0t: page mismatch expected=%h actual=%h", $time, e.page, pg);
        errors++;
      end
      if (fault !== e.fault) begin
        $display("%0t: fault mismatch on page %h expected=%b actual=%b",
                 $time, e.page, e.fault, fault);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [FramesCfgW-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PageFieldW-1:0] s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PageFieldW-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  lru_recency_tracker tracker = new();
  bit                 steady  = 1'b0;
  int unsigned        cycles  = 0;
  int unsigned        refs_sent = 0;

  lru_page_replacement #(
    .FRAMES   (Frames),
    .PAGE_BITS(PageBitsDefault)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d beats outstanding", $time, tracker.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 19);
  end

  // Inputs only move at posedge, so the negedge view is what the next edge accepts.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  task automatic send_page(input logic [PageFieldW-1:0] pg);
    while (!steady && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pg;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    tracker.note_reference(pg);
    refs_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_frames(input logic [FramesCfgW-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_frames(v);
  endtask

  initial begin
    logic [FramesCfgW-1:0] phase_frames [11];
    logic [PageFieldW-1:0] base;
    int unsigned           lim;
    int unsigned           pool;
    phase_frames = '{7'd1, 7'd2, 7'd4, 7'd8, 7'd17, 7'd64, 7'd33, 7'd63, 7'd127, 7'd0, 7'd5};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes at reset frame count, then hits
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
    send_page(16'h5555);
    // Frame count lowered while occupied: deeper page no longer resident
    set_frames(7'd2);
    send_page(16'hFFFF);
    send_page(16'h5555);
    // Single frame: a miss replaces the resident page
    set_frames(7'd1);
    send_page(16'h0007);
    send_page(16'h0007);
    send_page(16'h0008);
    send_page(16'h0007);
    // Zero acts as one frame
    set_frames(7'd0);
    send_page(16'h0007);
    send_page(16'h0009);
    // Three frames: hit at the deepest slot, then eviction
    set_frames(7'd3);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0003);
    send_page(16'h0001);
    send_page(16'h0004);
    send_page(16'h0002);
    // Above the built depth saturates
    set_frames(7'd127);
    send_page(16'h0002);
    send_page(16'h1234);

    // Random phases over several frame counts; mostly a small working set
    foreach (phase_frames[p]) begin
      set_frames(phase_frames[p]);
      lim = (phase_frames[p] == 0) ? 1 :
            (32'(phase_frames[p]) > Frames) ? Frames : 32'(phase_frames[p]);
      pool = $urandom_range(2 * lim + 2, 1);
      base = PageFieldW'($urandom);
      steady = (p == 5);
      repeat (158) begin
        if ($urandom_range(99) < 78) send_page(PageFieldW'(base + $urandom_range(pool - 1)));
        else send_page(PageFieldW'($urandom));
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (Frames + 10) @(posedge clk_i);
    $display("Ran %0d page references over %0d frame settings from 0 to 127",
             refs_sent, 17);
    $display("Observed %0d faults and %0d hits", tracker.faults, tracker.hits);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: lru_page_replacement.f
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_cell.sv
hw/rtl/lru_page_replacement.sv
tb/tb_lru_page_replacement.sv
